// ----- sv/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment label colorizer package
// Shared types, register codes and constants of the label colorizer.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int unsigned LBL_W       = 8;   // label index width
  localparam int unsigned RGB_W       = 24;  // color channels width
  localparam int unsigned ALPHA_W     = 8;   // alpha channel width
  localparam int unsigned RGBA_W      = RGB_W + ALPHA_W;
  localparam int unsigned THR_W       = 16;  // threshold width, Q4.12
  localparam int unsigned FRAC_BITS   = 12;  // fraction bits of Q4.12
  localparam int unsigned CFG_DATA_W  = 24;  // widest register
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic MODE_ARGMAX = 1'b0;
  localparam logic MODE_LABEL  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECODE_MODE     = 2'd0,
    REG_LABEL_COUNT     = 2'd1,
    REG_COLOR_STEP      = 2'd2,
    REG_SCORE_THRESHOLD = 2'd3
  } cfg_reg_e;

  localparam logic [LBL_W-1:0] RST_LABEL_COUNT     = 8'd20;
  localparam logic [RGB_W-1:0] RST_COLOR_STEP      = 24'd798915;
  localparam logic [THR_W-1:0] RST_SCORE_THRESHOLD = 16'd2048;

  typedef logic [LBL_W-1:0] lbl_t;

  typedef struct packed {
    logic             decode_mode;
    logic [LBL_W-1:0] label_count;
    logic [RGB_W-1:0] color_step;
    logic [THR_W-1:0] score_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/slc_if.sv -----
// ----------------------------------------------------------------------------
// Segment label colorizer channels
// Valid/ready channels for the score stream and the pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface slc_score_if #(
  parameter int unsigned SCORE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

interface slc_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] rgba;
  logic [7:0]  label;

  modport source (output valid, output rgba, output label, input ready);
  modport sink   (input valid, input rgba, input label, output ready);
endinterface

`default_nettype wire

// ----- sv/segment_label_colorizer_top.sv -----
// A decided label is written into the label queue, then into the output register the sink reads.
// Throughput: one score per cycle while the queue has room; the argmax compare is combinational.
// A two-entry label queue and the output register keep scores flowing while the sink stalls.
// Reset (async, active low) clears the argmax state, the queue and the output valid, and
// loads the register defaults: argmax mode, 20 labels, step 798915, threshold 0.5.
// ----------------------------------------------------------------------------
// Segment label colorizer top level
// Decode segmentation scores into labels and RGBA pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_label_colorizer_top #(
  parameter int unsigned SCORE_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [slc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [slc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  slc_score_if.sink                                score_i,
  slc_pixel_if.source                              pixel_o
);
  import slc_pkg::*;

  cfg_t cfg_q;
  logic clr;
  logic push;
  lbl_t push_lbl;
  logic q_full;
  logic q_valid;
  lbl_t q_lbl;
  logic pop;

  // Register file: write-only; write it only while the block is idle, which it does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode     <= MODE_ARGMAX;
      cfg_q.label_count     <= RST_LABEL_COUNT;
      cfg_q.color_step      <= RST_COLOR_STEP;
      cfg_q.score_threshold <= RST_SCORE_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DECODE_MODE:     cfg_q.decode_mode     <= cfg_wdata_i[0];
        REG_LABEL_COUNT:     cfg_q.label_count     <= cfg_wdata_i[LBL_W-1:0];
        REG_COLOR_STEP:      cfg_q.color_step      <= cfg_wdata_i[RGB_W-1:0];
        REG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_wdata_i[THR_W-1:0];
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  // A mode or count change restarts the pixel in progress.
  assign clr = cfg_we_i && ((cfg_reg_e'(cfg_idx_i) == REG_DECODE_MODE) ||
                            (cfg_reg_e'(cfg_idx_i) == REG_LABEL_COUNT));

  // Front end: accept scores, run the argmax, decide the label.
  slc_front #(
    .SCORE_BITS (SCORE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clr_i      (clr),
    .score_i    (score_i),
    .full_i     (q_full),
    .push_o     (push),
    .push_lbl_o (push_lbl)
  );

  // Decouple the two halves so each can stall on its own.
  slc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_lbl_i (push_lbl),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .lbl_o      (q_lbl)
  );

  // Back end: color the label and hold the pixel request.
  slc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_lbl_i   (q_lbl),
    .pop_o     (pop),
    .pixel_o   (pixel_o)
  );

  // Every accepted score in label mode decides a pixel at once.
  a_label_mode_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (score_i.valid && score_i.ready && (cfg_q.decode_mode == MODE_LABEL)) |-> push)
    else $error("label-mode score did not produce a pixel");

  // Never overwrite a pixel request the sink has not taken.
  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_o.valid && !pixel_o.ready) |-> !pop)
    else $error("queue popped while output stalled");

  // Alpha is opaque exactly for object labels.
  a_alpha_matches_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_o.valid |-> ((pixel_o.label != '0) == (pixel_o.rgba[RGBA_W-1:RGB_W] == ALPHA_OPAQUE)))
    else $error("alpha does not match label");

endmodule

`default_nettype wire

// ----- sv/slc_front.sv -----
// ----------------------------------------------------------------------------
// Segment label colorizer front end
// Accept scores, track the running argmax and decide each pixel's label.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front #(
  parameter int unsigned SCORE_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire slc_pkg::cfg_t  cfg_i,
  input  wire logic           clr_i,
  slc_score_if.sink           score_i,
  input  wire logic           full_i,
  output logic                push_o,
  output slc_pkg::lbl_t       push_lbl_o
);
  import slc_pkg::*;

  localparam int unsigned TH_W  = (SCORE_BITS > THR_W) ? SCORE_BITS : THR_W;
  localparam int unsigned CMP_W = (SCORE_BITS > LBL_W) ? SCORE_BITS : LBL_W;

  logic [LBL_W-1:0]             cnt_q, cnt_d;
  logic signed [SCORE_BITS-1:0] best_q, best_d;
  logic [LBL_W-1:0]             best_lbl_q, best_lbl_d;

  logic signed [SCORE_BITS-1:0] s;
  logic                         take;
  logic                         upd;
  logic                         last;
  logic [SCORE_BITS-1:0]        idx_wide;
  logic                         idx_ok;
  logic [LBL_W-1:0]             arg_lbl;
  logic                         arg_ok;
  logic                         label_mode;

  assign s             = score_i.score;
  assign score_i.ready = !full_i;
  assign take          = score_i.valid && score_i.ready;
  assign label_mode    = (cfg_i.decode_mode == MODE_LABEL);

  // Running argmax: the first score of a pixel always wins, ties keep the older label.
  assign upd        = (cnt_q == '0) || (s > best_q);
  assign best_d     = upd ? s : best_q;
  assign best_lbl_d = upd ? cnt_q : best_lbl_q;
  assign last       = (cnt_q >= cfg_i.label_count);
  assign cnt_d      = last ? '0 : LBL_W'(cnt_q + 1'b1);

  assign arg_lbl = (TH_W'(best_d) > TH_W'($signed(cfg_i.score_threshold))) ? best_lbl_d : '0;
  assign arg_ok  = (arg_lbl != '0) && (arg_lbl <= cfg_i.label_count);

  // Label mode: integer part of a nonnegative Q4.12 value.
  assign idx_wide = s[SCORE_BITS-1] ? '0 : ($unsigned(s) >> FRAC_BITS);
  assign idx_ok   = (idx_wide != '0) && (CMP_W'(idx_wide) <= CMP_W'(cfg_i.label_count));

  assign push_o = take && (label_mode || last);

  always_comb begin
    if (label_mode) begin
      push_lbl_o = idx_ok ? LBL_W'(idx_wide) : '0;
    end else begin
      push_lbl_o = arg_ok ? arg_lbl : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      best_q     <= '0;
      best_lbl_q <= '0;
    end else if (clr_i) begin
      cnt_q <= '0;
    end else if (take && !label_mode) begin
      cnt_q      <= cnt_d;
      best_q     <= best_d;
      best_lbl_q <= best_lbl_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/slc_queue.sv -----
// ----------------------------------------------------------------------------
// Segment label colorizer label queue
// Short FIFO of decided labels between the front end and the color stage.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire slc_pkg::lbl_t push_lbl_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output slc_pkg::lbl_t      lbl_o
);
  import slc_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  lbl_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign valid_o = (cnt_q != '0);
  assign lbl_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_lbl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_C) ? '0 : PTR_W'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_C) ? '0 : PTR_W'(rd_q + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
        2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/slc_back.sv -----
// ----------------------------------------------------------------------------
// Segment label colorizer back end
// Color a decided label and hold the pixel in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire slc_pkg::cfg_t cfg_i,
  input  wire logic          q_valid_i,
  input  wire slc_pkg::lbl_t q_lbl_i,
  output logic               pop_o,
  slc_pixel_if.source        pixel_o
);
  import slc_pkg::*;

  localparam int unsigned PROD_W = RGB_W + LBL_W;

  logic              out_v_q;
  logic [RGBA_W-1:0] rgba_q, rgba_d;
  lbl_t              label_q;
  logic [PROD_W-1:0] prod;

  assign pop_o = q_valid_i && (!out_v_q || pixel_o.ready);

  // Palette: color_step * label, wrapped to 24 bits, opaque alpha; label 0 gives an all-zero pixel.
  assign prod   = PROD_W'(cfg_i.color_step) * PROD_W'(q_lbl_i);
  assign rgba_d = (q_lbl_i != '0) ? {ALPHA_OPAQUE, prod[RGB_W-1:0]} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pop_o) begin
      out_v_q <= 1'b1;
    end else if (pixel_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rgba_q  <= rgba_d;
      label_q <= q_lbl_i;
    end
  end

  assign pixel_o.valid = out_v_q;
  assign pixel_o.rgba  = rgba_q;
  assign pixel_o.label = label_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment label colorizer testbench
// Runs a short directed table and then random score streams through the
// colorizer. A cycle-free predictor computes the expected pixels. Both
// channels idle and stall at random, and the sink holds off long enough
// to back up the whole pipeline.
// ----------------------------------------------------------------------------

module tb;
  import slc_pkg::*;

  localparam int SETTLE_CYCLES    = 6;
  localparam int HOLD_CYCLES      = 300;   // long sink hold-off
  localparam int WATCHDOG_LIMIT   = 3000;  // cycles without any request moving
  localparam int SHOWN_MISMATCHES = 10;
  localparam int PICK             = 1 << 30;  // phase field: pick at random

  typedef struct packed {
    logic [RGBA_W-1:0] rgba;
    lbl_t              label;
  } pixel_t;

  // ROW_SCORE rows are checked against the predictor, ROW_CHECK rows
  // against the pixel typed into the row.
  typedef enum logic [1:0] {ROW_CFG, ROW_SCORE, ROW_CHECK} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;   // register value, or score in bits 15..0
    logic [RGBA_W-1:0]     rgba;
    lbl_t                  label;
  } dir_row_t;

  typedef struct packed {
    logic mode;
    int   count;
    int   stepv;
    int   thr;
    int   gap;
    int   stall;
    bit   press;
    int   items;
  } phase_t;

  // Directed part. Registers start at reset: argmax, 20 labels, step
  // 0x0C30C3, threshold 0.5.
  dir_row_t dir_rows [38] = '{
    // label mode with reset palette: label 1, label 7, negative, truncation
    '{ROW_CFG,   REG_DECODE_MODE,     24'h000001, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h001000, 32'hFF0C30C3, 8'd1},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h007FFF, 32'hFF555555, 8'd7},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h008000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h002FFF, 32'hFF186186, 8'd2},
    // label above the count, label at the count
    '{ROW_CFG,   REG_LABEL_COUNT,     24'h000005, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h006000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h005000, 32'hFF3CF3CF, 8'd5},
    // palette product wraps at 24 bits; zero step leaves only alpha
    '{ROW_CFG,   REG_COLOR_STEP,      24'hFFFFFF, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h003000, 32'hFFFFFFFD, 8'd3},
    '{ROW_CFG,   REG_COLOR_STEP,      24'h000000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h001000, 32'hFF000000, 8'd1},
    // argmax, three scores per pixel
    '{ROW_CFG,   REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_CFG,   REG_LABEL_COUNT,     24'h000002, 32'h0,        8'd0},
    '{ROW_CFG,   REG_COLOR_STEP,      24'h0C30C3, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h007FFF, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h000064, 32'hFF0C30C3, 8'd1},
    // winner ties the threshold
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000800, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h000800, 32'h0,        8'd0},
    // first label to reach the max keeps it
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000BB8, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000BB8, 32'h0,        8'd0},
    // open a pixel, then restart it by a mode write
    '{ROW_SCORE, REG_DECODE_MODE,     24'h001388, 32'h0,        8'd0},
    '{ROW_CFG,   REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h001000, 32'hFF186186, 8'd2},
    // zero labels: every score is a background pixel
    '{ROW_CFG,   REG_LABEL_COUNT,     24'h000000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h007FFF, 32'h0,        8'd0},
    // threshold extremes
    '{ROW_CFG,   REG_LABEL_COUNT,     24'h000001, 32'h0,        8'd0},
    '{ROW_CFG,   REG_SCORE_THRESHOLD, 24'h008000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h008000, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h008001, 32'h0,        8'd0},
    '{ROW_CFG,   REG_SCORE_THRESHOLD, 24'h007FFF, 32'h0,        8'd0},
    '{ROW_SCORE, REG_DECODE_MODE,     24'h000000, 32'h0,        8'd0},
    '{ROW_CHECK, REG_DECODE_MODE,     24'h007FFF, 32'h0,        8'd0}
  };

  // Random phases: register setting, idle profile, sink hold-off, length.
  // Label count 255 gets one full pixel only in argmax mode; the other counts stay small.
  phase_t phases [8] = '{
    '{MODE_ARGMAX, 3,    PICK,     2048,   0,  0,  1'b0, 150},
    '{MODE_LABEL,  255,  'hFFFFFF, PICK,   75, 0,  1'b0, 100},
    '{MODE_ARGMAX, 1,    0,        -32768, 0,  75, 1'b0, 150},
    '{MODE_ARGMAX, 255,  PICK,     PICK,   8,  8,  1'b0, 260},
    '{MODE_LABEL,  PICK, PICK,     PICK,   0,  0,  1'b1, 150},
    '{MODE_ARGMAX, PICK, PICK,     32767,  75, 0,  1'b0, 100},
    '{MODE_ARGMAX, 0,    PICK,     PICK,   8,  8,  1'b0, 60},
    '{MODE_ARGMAX, PICK, PICK,     PICK,   0,  75, 1'b1, 150}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slc_score_if #(.SCORE_BITS(16)) score_ch ();
  slc_pixel_if                    pixel_ch ();

  segment_label_colorizer_top #(
    .SCORE_BITS (16)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .score_i     (score_ch),
    .pixel_o     (pixel_ch)
  );

  // Predictor copy of the registers and of the argmax state.
  logic                   dec_mode;
  lbl_t                   lbl_count;
  logic [RGB_W-1:0]       step;
  logic signed [THR_W-1:0] thresh;
  lbl_t                   pos;
  logic signed [15:0]     top_score;
  lbl_t                   top_label;
  logic signed [15:0]     last_score;

  pixel_t pixels_due [$];   // expected pixels, oldest first

  int gap_pct      = 0;
  int stall_pct    = 0;
  int hold_reqs    = 0;
  int hold_served  = 0;
  int hold_left    = 0;
  int mismatches   = 0;
  int pixel_no     = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Color of a decided label; background and labels past the count are 0.
  function automatic pixel_t palette_color(input lbl_t lab);
    pixel_t      px;
    logic [31:0] prod;
    px = '0;
    if (lab != '0 && lab <= lbl_count) begin
      prod     = step * lab;
      px.rgba  = {ALPHA_OPAQUE, prod[RGB_W-1:0]};
      px.label = lab;
    end
    return px;
  endfunction

  // Advance the predictor by one score; return 1 when a pixel is decided.
  function automatic bit predict_pixel(input logic signed [15:0] s, output pixel_t px);
    lbl_t lab;
    px = '0;
    if (dec_mode == MODE_LABEL) begin
      // Q4.12 index truncated toward zero; negative means background
      lab = s[15] ? lbl_t'(0) : {5'b0, s[14:12]};
      px  = palette_color(lab);
      return 1'b1;
    end
    if (pos == '0 || s > top_score) begin
      top_score = s;
      top_label = pos;
    end
    if (pos >= lbl_count) begin
      pos = '0;
      px  = palette_color(top_score > thresh ? top_label : lbl_t'(0));
      return 1'b1;
    end
    pos = pos + 1'b1;
    return 1'b0;
  endfunction

  // Write one register with the block idle: drop the score request, wait
  // for every pending pixel, then let the pipeline settle.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    score_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DECODE_MODE: begin
        dec_mode = data[0];
        pos      = '0;
      end
      REG_LABEL_COUNT: begin
        lbl_count = data[LBL_W-1:0];
        pos       = '0;
      end
      REG_COLOR_STEP:      step   = data[RGB_W-1:0];
      REG_SCORE_THRESHOLD: thresh = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one score request after a random gap and return at the edge that
  // takes it. Valid stays high so a following request goes out back to back.
  task automatic send_score(input logic [15:0] s, input bit typed, input pixel_t want);
    pixel_t px;
    while ($urandom_range(99) < gap_pct) begin
      score_ch.valid <= 1'b0;
      @(posedge clk);
    end
    score_ch.valid <= 1'b1;
    score_ch.score <= s;
    do @(posedge clk); while (!score_ch.ready);
    if (predict_pixel(s, px)) pixels_due.push_back(typed ? want : px);
    last_score = s;
  endtask

  // Sink: stall at random, or hold off for a long stretch when asked.
  initial begin
    pixel_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pixel_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_reqs != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        pixel_ch.ready <= 1'b0;
      end else begin
        pixel_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every pixel the sink takes against the oldest expectation.
  always @(posedge clk) begin : check_pixel
    pixel_t want;
    if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("pixel %0d not expected: rgba %08h label %0d",
                   pixel_no, pixel_ch.rgba, pixel_ch.label);
      end else begin
        want = pixels_due.pop_front();
        if (pixel_ch.rgba !== want.rgba) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("pixel %0d rgba: expected %08h, got %08h",
                     pixel_no, want.rgba, pixel_ch.rgba);
        end
        if (pixel_ch.label !== want.label) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("pixel %0d label: expected %0d, got %0d",
                     pixel_no, want.label, pixel_ch.label);
        end
      end
      pixel_no++;
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if ((score_ch.valid && score_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    dir_row_t              row;
    phase_t                ph;
    logic [CFG_DATA_W-1:0] d;
    logic [15:0]           s;

    // Drive every input to a known value and hold reset.
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_DECODE_MODE;
    cfg_wdata      = '0;
    score_ch.valid = 1'b0;
    score_ch.score = '0;

    // Predictor starts at the block's reset values.
    dec_mode   = MODE_ARGMAX;
    lbl_count  = 8'd20;
    step       = 24'd798915;
    thresh     = 16'sd2048;
    pos        = '0;
    top_score  = '0;
    top_label  = '0;
    last_score = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with both sides running flat out.
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG)
        write_reg(row.idx, row.data);
      else
        send_score(row.data[15:0], row.kind == ROW_CHECK, pixel_t'({row.rgba, row.label}));
    end

    // Random phases. Spare register bits get random values; the block
    // must ignore them.
    foreach (phases[p]) begin
      ph = phases[p];
      d    = CFG_DATA_W'($urandom);
      d[0] = ph.mode;
      write_reg(REG_DECODE_MODE, d);
      d        = CFG_DATA_W'($urandom);
      d[7:0]   = (ph.count == PICK) ? 8'($urandom_range(1, 7)) : 8'(ph.count);
      write_reg(REG_LABEL_COUNT, d);
      write_reg(REG_COLOR_STEP,
                (ph.stepv == PICK) ? CFG_DATA_W'($urandom) : CFG_DATA_W'(ph.stepv));
      d        = CFG_DATA_W'($urandom);
      d[15:0]  = (ph.thr == PICK) ? 16'($urandom) : 16'(ph.thr);
      write_reg(REG_SCORE_THRESHOLD, d);

      gap_pct   = ph.gap;
      stall_pct = ph.stall;
      // Hold the sink off while the source keeps offering, so the queue
      // fills and the score channel stalls.
      if (ph.press) hold_reqs++;

      repeat (ph.items) begin
        if (dec_mode == MODE_LABEL) begin
          // at least half the requests carry a non-negative index 0..7
          s = 16'($urandom);
          if ($urandom_range(1) == 1) s[15] = 1'b0;
        end else begin
          // favor extremes, threshold hits and repeated scores
          case ($urandom_range(7))
            0:       s = 16'h7FFF;
            1:       s = 16'h8000;
            2:       s = thresh;
            3:       s = last_score;
            default: s = 16'($urandom);
          endcase
        end
        send_score(s, 1'b0, '0);
      end
    end

    // Drop the source, drain what is pending, and watch for stray pixels.
    score_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
